// File: sv/arst_pkg.sv
// shared constants, types and command/status structs for the alternating range sum tree
package arst_pkg;

    localparam int ENTRIES = 1024;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int LEN_W   = IDX_W + 1;
    localparam int NODES   = 2 * ENTRIES;
    localparam int ADDR_W  = $clog2(NODES);
    localparam int VAL_W   = 32;
    localparam int SUM_W   = 48;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [SUM_W-1:0]  t_sum;

    // controller to datapath
    typedef struct packed {
        logic clr_restart;
        logic clr_step;
        logic load;
        logic elem_rd;
        logic elem_wr;
        logic upd_step;
        logic qry_step;
        logic qry_init1;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic is_query;
        logic bad_write;
        logic bad_query;
        logic upd_leaf;
        logic qry_done;
        logic out_free;
    } t_dp_status;

endpackage

// File: sv/arst_ctrl.sv
// sequencing state machine for clear, update and query passes
module arst_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  arst_pkg::t_dp_status i_status,
    output arst_pkg::t_dp_cmd    o_cmd
);
    import arst_pkg::*;

    localparam logic [3:0] ST_CLEAR      = 4'd0;
    localparam logic [3:0] ST_IDLE       = 4'd1;
    localparam logic [3:0] ST_DISPATCH   = 4'd2;
    localparam logic [3:0] ST_ELEM_RD    = 4'd3;
    localparam logic [3:0] ST_ELEM_DELTA = 4'd4;
    localparam logic [3:0] ST_UPD_WALK   = 4'd5;
    localparam logic [3:0] ST_UPD_DRAIN  = 4'd6;
    localparam logic [3:0] ST_QRY_WALK   = 4'd7;
    localparam logic [3:0] ST_QRY_INIT1  = 4'd8;
    localparam logic [3:0] ST_QRY_DRAIN  = 4'd9;
    localparam logic [3:0] ST_QRY_OUT    = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_walk;
    logic       n_walk;

    // no item is taken in the cycle a length write restarts the clearing pass
    assign o_in_ready = (r_state == ST_IDLE) && !i_cfg_valid;

    always_comb begin
        n_state = r_state;
        n_walk  = r_walk;
        o_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_walk     = 1'b0;
                    n_state    = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (i_status.is_query) begin
                    n_state = i_status.bad_query ? ST_QRY_OUT : ST_QRY_WALK;
                end else begin
                    n_state = i_status.bad_write ? ST_IDLE : ST_ELEM_RD;
                end
            end
            ST_ELEM_RD: begin
                o_cmd.elem_rd = 1'b1;
                n_state       = ST_ELEM_DELTA;
            end
            ST_ELEM_DELTA: begin
                o_cmd.elem_wr = 1'b1;
                n_state       = ST_UPD_WALK;
            end
            ST_UPD_WALK: begin
                o_cmd.upd_step = 1'b1;
                if (i_status.upd_leaf) begin
                    n_state = ST_UPD_DRAIN;
                end
            end
            ST_UPD_DRAIN: begin
                n_state = ST_IDLE;
            end
            ST_QRY_WALK: begin
                o_cmd.qry_step = 1'b1;
                if (i_status.qry_done) begin
                    n_state = r_walk ? ST_QRY_DRAIN : ST_QRY_INIT1;
                end
            end
            ST_QRY_INIT1: begin
                o_cmd.qry_init1 = 1'b1;
                n_walk          = 1'b1;
                n_state         = ST_QRY_WALK;
            end
            ST_QRY_DRAIN: begin
                n_state = ST_QRY_OUT;
            end
            ST_QRY_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
        // a length write reshapes the tree: restart the clearing pass
        if (i_cfg_valid) begin
            o_cmd           = '0;
            o_cmd.clr_restart = 1'b1;
            n_state         = ST_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_walk  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_walk  <= n_walk;
        end
    end

endmodule

// File: sv/arst_datapath.sv
// tree store, element store, node walker, accumulators and output register
module arst_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  arst_pkg::t_dp_cmd         i_cmd,
    output arst_pkg::t_dp_status      o_status,
    input  logic                      i_cfg_valid,
    input  logic [arst_pkg::LEN_W-1:0] i_cfg_data,
    input  logic                      i_in_command,
    input  logic [arst_pkg::IDX_W-1:0] i_in_index,
    input  logic [arst_pkg::IDX_W-1:0] i_in_right,
    input  logic [arst_pkg::VAL_W-1:0] i_in_value,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [arst_pkg::SUM_W-1:0] o_out_sum,
    output logic                      o_out_error
);
    import arst_pkg::*;

    // tree and element memories
    t_sum             mem_even [NODES];
    t_sum             mem_odd  [NODES];
    logic [VAL_W-1:0] mem_elem [ENTRIES];

    t_len  r_len;
    t_addr r_clr_cnt;

    logic             r_cmd;
    t_idx             r_l;
    t_idx             r_r;
    logic [VAL_W-1:0] r_val;

    // node walker
    t_addr r_node;
    t_idx  r_s;
    t_idx  r_e;
    t_len  r_k;
    logic  r_walk;

    t_sum             r_rd_even;
    t_sum             r_rd_odd;
    logic [VAL_W-1:0] r_elem_rd;
    t_sum             r_delta;

    logic  r_rmw_vld;
    t_addr r_rmw_addr;
    logic  r_rmw_par;
    logic  r_acc_vld;
    logic  r_acc_neg;
    t_sum  r_acc_e;
    t_sum  r_acc_o;

    logic r_out_valid;
    t_sum r_out_sum;
    logic r_out_err;

    t_idx  w_half;
    t_idx  w_mid;
    t_addr w_left;
    t_addr w_right;
    logic  w_k_gt_e;
    logic  w_k_eq_s;
    logic  w_k_gt_mid;
    t_addr w_rd_addr;
    logic  w_wr_en;
    t_addr w_wr_addr;
    t_sum  w_wr_even;
    t_sum  w_wr_odd;
    t_len  w_cfg_len;
    t_idx  w_last;
    logic  w_bad_write;
    logic  w_bad_query;

    assign w_half     = (r_e - r_s) >> 1;
    assign w_mid      = r_s + w_half;
    assign w_left     = r_node + t_addr'(1);
    assign w_right    = r_node + ((t_addr'(w_half) + t_addr'(1)) << 1);
    assign w_k_gt_e   = r_k > {1'b0, r_e};
    assign w_k_eq_s   = r_k == {1'b0, r_s};
    assign w_k_gt_mid = r_k > {1'b0, w_mid};
    assign w_last     = t_idx'(r_len - t_len'(1));

    assign w_bad_write = ({1'b0, r_l} >= r_len);
    assign w_bad_query = ({1'b0, r_l} >= r_len) || ({1'b0, r_r} >= r_len) || (r_l > r_r);

    always_comb begin
        if (i_cfg_data == '0) begin
            w_cfg_len = t_len'(1);
        end else if (i_cfg_data > t_len'(ENTRIES)) begin
            w_cfg_len = t_len'(ENTRIES);
        end else begin
            w_cfg_len = i_cfg_data;
        end
    end

    // a query reads the left child when the boundary lies within the node span, else the node itself
    assign w_rd_addr = (i_cmd.qry_step && !w_k_gt_e) ? w_left : r_node;

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_rmw_addr;
        w_wr_even = r_rd_even;
        w_wr_odd  = r_rd_odd;
        if (i_cmd.clr_step) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr_cnt;
            w_wr_even = '0;
            w_wr_odd  = '0;
        end else if (r_rmw_vld) begin
            w_wr_en = 1'b1;
            if (r_rmw_par) begin
                w_wr_odd = r_rd_odd + r_delta;
            end else begin
                w_wr_even = r_rd_even + r_delta;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem_even[w_wr_addr] <= w_wr_even;
            mem_odd[w_wr_addr]  <= w_wr_odd;
        end
        r_rd_even <= mem_even[w_rd_addr];
        r_rd_odd  <= mem_odd[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            mem_elem[r_clr_cnt[IDX_W-1:0]] <= '0;
        end else if (i_cmd.elem_wr) begin
            mem_elem[r_l] <= r_val;
        end
        if (i_cmd.elem_rd) begin
            r_elem_rd <= mem_elem[r_l];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= t_len'(ENTRIES);
            r_clr_cnt   <= '0;
            r_rmw_vld   <= 1'b0;
            r_acc_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_len <= w_cfg_len;
            end
            if (i_cmd.clr_restart) begin
                r_clr_cnt <= '0;
            end else if (i_cmd.clr_step) begin
                r_clr_cnt <= r_clr_cnt + t_addr'(1);
            end
            r_rmw_vld <= i_cmd.upd_step;
            // only a span wholly below the boundary is added: the whole root or a left child
            r_acc_vld <= i_cmd.qry_step && w_k_gt_mid;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item, walker and accumulator registers
    always_ff @(posedge i_clk) begin
        r_rmw_addr <= r_node;
        r_rmw_par  <= r_l[0] ^ r_s[0];
        r_acc_neg  <= r_s[0] ^ r_walk ^ r_l[0];
        if (i_cmd.elem_wr) begin
            r_delta <= SUM_W'($signed(r_val)) - SUM_W'($signed(r_elem_rd));
        end
        if (i_cmd.load) begin
            r_cmd   <= i_in_command;
            r_l     <= i_in_index;
            r_r     <= i_in_right;
            r_val   <= i_in_value;
            r_node  <= '0;
            r_s     <= '0;
            r_e     <= w_last;
            r_k     <= {1'b0, i_in_right} + t_len'(1);
            r_walk  <= 1'b0;
            r_acc_e <= '0;
            r_acc_o <= '0;
        end else begin
            if (i_cmd.qry_init1) begin
                r_node <= '0;
                r_s    <= '0;
                r_e    <= w_last;
                r_k    <= {1'b0, r_l};
                r_walk <= 1'b1;
            end else if (i_cmd.upd_step && (r_s != r_e)) begin
                if (r_l <= w_mid) begin
                    r_node <= w_left;
                    r_e    <= w_mid;
                end else begin
                    r_node <= w_right;
                    r_s    <= w_mid + t_idx'(1);
                end
            end else if (i_cmd.qry_step && !w_k_gt_e && !w_k_eq_s) begin
                if (w_k_gt_mid) begin
                    r_node <= w_right;
                    r_s    <= w_mid + t_idx'(1);
                end else begin
                    r_node <= w_left;
                    r_e    <= w_mid;
                end
            end
            if (r_acc_vld) begin
                if (r_acc_neg) begin
                    r_acc_e <= r_acc_e + r_rd_odd;
                    r_acc_o <= r_acc_o + r_rd_even;
                end else begin
                    r_acc_e <= r_acc_e + r_rd_even;
                    r_acc_o <= r_acc_o + r_rd_odd;
                end
            end
        end
        if (i_cmd.out_load) begin
            r_out_sum <= w_bad_query ? '0 : (r_acc_e - r_acc_o);
            r_out_err <= w_bad_query;
        end
    end

    assign o_status.clr_last  = (r_clr_cnt == t_addr'(NODES - 1));
    assign o_status.is_query  = (r_cmd == CMD_QUERY);
    assign o_status.bad_write = w_bad_write;
    assign o_status.bad_query = w_bad_query;
    assign o_status.upd_leaf  = (r_s == r_e);
    assign o_status.qry_done  = w_k_eq_s || w_k_gt_e;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_sum   = r_out_sum;
    assign o_out_error = r_out_err;

`ifndef SYNTHESIS
    a_no_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rmw_vld |-> !i_cmd.clr_step)
        else $error("tree update write collides with clearing pass");

    a_acc_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc_vld |-> $past(i_cmd.qry_step))
        else $error("accumulate without a query read");

    a_walker_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.upd_step || i_cmd.qry_step) |-> (r_s <= r_e))
        else $error("walker node span reversed");

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while held");
`endif

endmodule

// File: sv/alternating_range_sum_tree.sv
// top level of the alternating range sum tree: stream ports, controller and datapath
// The block keeps up to 1024 signed 32-bit elements in a segment tree whose nodes hold
// the sums of elements at even and odd offset from the node start, in a 2048-entry memory.
// A write item (tuser 0) replaces one element and produces no result; a query item
// (tuser 1) returns a[l]-a[l+1]+a[l+2]-... up to a[r] as a 48-bit signed sum, with error
// set and sum 0 if either end is at or past active_length or l is greater than r. Items are
// handled one at a time, and a query waits until the result register is free. The node
// walker descends the tree (depth 10 at 1024 elements) with one read of the tree memories
// per level, once for the update path and twice for a query (once per range boundary).
// A query with a bad range skips both walks and returns its error result; a write with
// a bad index is dropped without touching the store. After reset and after every
// active_length write a clearing pass zeroes the store, during which no item is taken.
// Configuration is always accepted and must only be written while the block is idle.
module alternating_range_sum_tree (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: active_length
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // index[9:0], right_index[19:10], value[51:20], zero pad
    input  logic        s_axis_tuser,   // command
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // alternating_sum[47:0]
    output logic        m_axis_tuser    // error
);
    import arst_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // length writes can land any time the block is quiet
    assign o_cfg_ready = 1'b1;

    arst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // unpack the item fields from tdata, lowest field first
    arst_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_in_command (s_axis_tuser),
        .i_in_index   (s_axis_tdata[IDX_W-1:0]),
        .i_in_right   (s_axis_tdata[2*IDX_W-1:IDX_W]),
        .i_in_value   (s_axis_tdata[2*IDX_W+VAL_W-1:2*IDX_W]),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_sum    (m_axis_tdata),
        .o_out_error  (m_axis_tuser)
    );

endmodule

// File: dv/tb_alternating_range_sum_tree.sv
// testbench for the alternating range sum tree: stream driver, result scoreboard, run control
`timescale 1ns / 1ps

module tb_alternating_range_sum_tree;

    import arst_pkg::*;

    // one expected result item
    typedef struct packed {
        t_sum sum;
        logic err;
    } t_alt_result;

    // mirror of the element array; the alternating sum is taken straight from the elements
    class alt_sum_board;
        longint          elems [ENTRIES];
        int unsigned     active_len;
        t_alt_result     awaited [$];
        int unsigned     mismatches;

        function new();
            mismatches = 0;
            set_length(ENTRIES);
        endfunction

        // a length write clamps to 1..ENTRIES and wipes the whole array
        function void set_length(int unsigned req);
            active_len = (req < 1) ? 1 : (req > ENTRIES) ? ENTRIES : req;
            foreach (elems[k]) elems[k] = 0;
        endfunction

        function int unsigned waiting();
            return awaited.size();
        endfunction

        // accepted input item: writes update the mirror, queries queue a result
        function void note_input(logic cmd, t_idx lo, t_idx hi, logic signed [VAL_W-1:0] val);
            t_alt_result res;
            longint      acc;
            if (cmd == CMD_WRITE) begin
                // out-of-range writes are dropped silently
                if (lo < active_len) elems[lo] = val;
                return;
            end
            if (lo >= active_len || hi >= active_len || lo > hi) begin
                res.sum = '0;
                res.err = 1'b1;
            end else begin
                acc = 0;
                // sign is plus at the left end, parity relative to lo
                for (int k = lo; k <= hi; k++) begin
                    if ((k - lo) % 2 == 1) acc -= elems[k];
                    else acc += elems[k];
                end
                res.sum = t_sum'(acc);
                res.err = 1'b0;
            end
            awaited = {awaited, res};
        endfunction

        task report(string msg);
            $display("mismatch at %0t ns: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(t_sum sum, logic err);
            t_alt_result exp_res;
            if (awaited.size() == 0) begin
                report($sformatf("result sum=%h err=%b with no query waiting", sum, err));
                return;
            end
            exp_res = awaited.pop_front();
            if (sum !== exp_res.sum)
                report($sformatf("sum got %h want %h", sum, exp_res.sum));
            if (err !== exp_res.err)
                report($sformatf("error got %b want %b", err, exp_res.err));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [10:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;   // index[9:0], right_index[19:10], value[51:20], zero pad
    logic        s_axis_tuser;   // command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // alternating_sum[47:0]
    logic        m_axis_tuser;   // error

    alt_sum_board board;
    // no idling on either side while set
    bit          calm = 1'b0;

    alternating_range_sum_tree i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // both handshakes are sampled on the rising edge, inputs only move on the falling one
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            board.note_input(s_axis_tuser, s_axis_tdata[9:0], s_axis_tdata[19:10],
                             s_axis_tdata[51:20]);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tuser);
    end

    // result side backpressure: mostly ready, short stalls, now and then a long one
    initial begin
        int stall;
        int pick;
        stall = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (calm) begin
                m_axis_tready <= 1'b1;
            end else if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    m_axis_tready <= 1'b1;
                end else if (pick < 95) begin
                    stall = $urandom_range(0, 2);
                    m_axis_tready <= 1'b0;
                end else begin
                    stall = $urandom_range(9, 39);
                    m_axis_tready <= 1'b0;
                end
            end
        end
    end

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (calm || pick < 60) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // element values lean on the extremes so the 48-bit sums get exercised
    function automatic logic [VAL_W-1:0] pick_value();
        int small_val;
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: begin
                small_val = int'($urandom_range(0, 200)) - 100;
                return small_val;
            end
            default: return $urandom;
        endcase
    endfunction

    // tvalid is only lowered in a gap, never dropped and raised in one step
    task automatic send_item(logic cmd, t_idx lo, t_idx hi, logic [VAL_W-1:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'b0, val, hi, lo};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // stop sending, wait for every query answer, then let a trailing write settle
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (board.waiting() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_length(logic [10:0] len);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_length(len);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly in-range writes and well-formed ranges, some out-of-range noise
    task automatic run_random(int count);
        int          done;
        int unsigned lo;
        int unsigned hi;
        int unsigned len;
        int unsigned pick;
        done = 0;
        len  = board.active_len;
        while (done < count) begin
            if (done % 50 == 0) calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                if ($urandom_range(0, 9) == 0) lo = $urandom_range(0, ENTRIES - 1);
                else lo = $urandom_range(0, len - 1);
                hi = $urandom_range(0, ENTRIES - 1);
                send_item(CMD_WRITE, t_idx'(lo), t_idx'(hi), pick_value());
                // ignored writes do not count
                if (lo < len) done++;
            end else begin
                if (pick < 88) begin
                    lo = $urandom_range(0, len - 1);
                    if ($urandom_range(0, 2) == 0) begin
                        hi = lo + $urandom_range(0, 3);
                        if (hi > len - 1) hi = len - 1;
                    end else begin
                        hi = $urandom_range(lo, len - 1);
                    end
                end else begin
                    lo = $urandom_range(0, ENTRIES - 1);
                    hi = $urandom_range(0, ENTRIES - 1);
                end
                send_item(CMD_QUERY, t_idx'(lo), t_idx'(hi), $urandom);
                done++;
            end
        end
        drain();
    endtask

    initial begin
        logic [10:0] lengths [9];
        int          counts  [9];
        lengths = '{11'd1, 11'd2, 11'd3, 11'd2047, 11'd0, 11'd1025, 11'd16, 11'd100, 11'd0};
        counts  = '{120, 150, 150, 300, 80, 250, 250, 250, 150};
        board = new();
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_WRITE;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed at the reset length: extreme values at both ends of the array
        send_item(CMD_WRITE, 10'd0,    10'd0,    32'h7FFF_FFFF);
        send_item(CMD_WRITE, 10'd1023, 10'd1023, 32'h8000_0000);
        send_item(CMD_WRITE, 10'd1,    10'd0,    32'h8000_0000);
        send_item(CMD_WRITE, 10'd1022, 10'd0,    32'h7FFF_FFFF);
        send_item(CMD_WRITE, 10'd512,  10'd1023, 32'hFFFF_FFFF);
        send_item(CMD_QUERY, 10'd0,    10'd1023, 32'h0);
        send_item(CMD_QUERY, 10'd0,    10'd0,    32'h0);
        send_item(CMD_QUERY, 10'd1023, 10'd1023, 32'hFFFF_FFFF);
        send_item(CMD_QUERY, 10'd1,    10'd1022, 32'h0);
        send_item(CMD_QUERY, 10'd0,    10'd1,    32'h0);
        // reversed ranges
        send_item(CMD_QUERY, 10'd1023, 10'd0,    32'h0);
        send_item(CMD_QUERY, 10'd512,  10'd511,  32'h0);
        send_item(CMD_WRITE, 10'd0,    10'd0,    32'h0);
        send_item(CMD_QUERY, 10'd0,    10'd1023, 32'h0);
        drain();

        // short array: writes past the end are dropped, queries past it flag an error
        write_length(11'd5);
        send_item(CMD_WRITE, 10'd5,    10'd0,    32'h1234_5678);
        send_item(CMD_WRITE, 10'd1023, 10'd0,    32'h7FFF_FFFF);
        send_item(CMD_QUERY, 10'd0,    10'd4,    32'h0);
        send_item(CMD_QUERY, 10'd5,    10'd5,    32'h0);
        send_item(CMD_QUERY, 10'd0,    10'd1023, 32'h0);
        send_item(CMD_QUERY, 10'd4,    10'd4,    32'h0);
        send_item(CMD_WRITE, 10'd4,    10'd0,    32'h7FFF_FFFF);
        send_item(CMD_QUERY, 10'd0,    10'd4,    32'h0);
        drain();

        // back to the reset length contents for a random pass before reconfiguring
        write_length(11'd1024);
        run_random(230);

        // sweep of lengths, the clamped values 0, 1025 and 2047 among them
        lengths[8] = 11'($urandom_range(1, ENTRIES));
        foreach (lengths[p]) begin
            write_length(lengths[p]);
            run_random(counts[p]);
        end

        if (board.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: files.f
sv/arst_pkg.sv
sv/arst_ctrl.sv
sv/arst_datapath.sv
sv/alternating_range_sum_tree.sv
dv/tb_alternating_range_sum_tree.sv
